// ===== rtl/acbs_pkg.sv =====
package acbs_pkg;

    localparam int BLOCK_BYTES_DEF     = 16;
    localparam int ROUND_KEY_WORDS_DEF = 30;

    localparam logic [1:0] MODE_DATA    = 2'd0;
    localparam logic [1:0] MODE_KEY     = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [2:0] REG_IV_HIGH     = 3'd0;
    localparam logic [2:0] REG_IV_LOW      = 3'd1;
    localparam logic [2:0] REG_INIT_CTR    = 3'd2;
    localparam logic [2:0] REG_CTR_MASK    = 3'd3;
    localparam logic [2:0] REG_ROUND_COUNT = 3'd4;

    localparam logic [63:0] CTR_MASK_RESET    = 64'h0000_0000_FFFF_FFFF;
    localparam logic [3:0]  ROUND_COUNT_RESET = 4'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic take;       // latch accepted input word
        logic ks_load;    // load AES state from IV ^ counter
        logic ks_key0;    // add round key 0
        logic ks_round;   // run one round
        logic ks_last;    // this round is the final one
        logic [3:0] ks_rnd; // round number
        logic ks_done;    // copy state to keystream block
        logic finish;     // compute result and update counters
        logic out_load;   // load output register
    } acbs_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       need_ks;   // data byte at block start, not exhausted
        logic [3:0] nr;        // saturated round count
    } acbs_sts_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== rtl/acbs_ctrl.sv =====
module acbs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_free,
    input  acbs_pkg::acbs_sts_t sts,
    output acbs_pkg::acbs_cmd_t cmd,
    output logic                busy
);
    import acbs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DEC   = 5'b00010,
        ST_KEY0  = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 4'd1;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        cmd.ks_rnd = rnd_reg;
        cmd.ks_last = (rnd_reg == sts.nr);
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.take = in_fire;
                if (in_fire)
                    state_next = ST_DEC;
            end
            ST_DEC:
            begin
                if (sts.need_ks)
                begin
                    cmd.ks_load = 1'b1;
                    state_next  = ST_KEY0;
                end
                else
                    state_next = ST_DONE;
            end
            ST_KEY0:
            begin
                cmd.ks_key0 = 1'b1;
                rnd_next    = 4'd1;
                state_next  = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.ks_round = 1'b1;
                rnd_next     = rnd_reg + 4'd1;
                if (rnd_reg == sts.nr)
                begin
                    cmd.ks_done = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/acbs_dp.sv =====
module acbs_dp
#(
    parameter int ROUND_KEY_WORDS = acbs_pkg::ROUND_KEY_WORDS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic [1:0]          in_mode,
    input  logic [7:0]          in_data_byte,
    input  logic [4:0]          in_key_index,
    input  logic [63:0]         in_key_word,
    input  acbs_pkg::acbs_cmd_t cmd,
    output acbs_pkg::acbs_sts_t sts,
    output logic [7:0]          res_byte,
    output logic                res_ok
);
    import acbs_pkg::*;

    logic [63:0] iv_high_reg, iv_low_reg, init_ctr_reg, ctr_mask_reg;
    logic [3:0]  round_count_reg;
    logic [63:0] ctr_reg, ctr_next;
    logic [3:0]  pos_reg, pos_next;
    logic        exh_reg, exh_next;
    logic [1:0]  mode_reg;
    logic [7:0]  byte_reg;
    logic [127:0] ks_reg;
    logic [7:0]  st_reg [16];
    logic [7:0]  st_next [16];
    logic [63:0] rk_mem [ROUND_KEY_WORDS];
    logic [63:0] rk_hi, rk_lo;
    logic [63:0] lo_word;
    logic [7:0]  sb [16];
    logic [7:0]  mc [16];
    logic [63:0] idx;
    logic [3:0]  kr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_high_reg     <= '0;
            iv_low_reg      <= '0;
            init_ctr_reg    <= '0;
            ctr_mask_reg    <= CTR_MASK_RESET;
            round_count_reg <= ROUND_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IV_HIGH:     iv_high_reg     <= cfg_data;
                REG_IV_LOW:      iv_low_reg      <= cfg_data;
                REG_INIT_CTR:    init_ctr_reg    <= cfg_data;
                REG_CTR_MASK:    ctr_mask_reg    <= cfg_data;
                REG_ROUND_COUNT: round_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mode_reg <= in_mode;
            byte_reg <= in_data_byte;
            if (in_mode == MODE_KEY && in_key_index < 5'(ROUND_KEY_WORDS))
                rk_mem[in_key_index] <= in_key_word;
        end
    end

    assign sts.mode    = mode_reg;
    assign sts.need_ks = (mode_reg == MODE_DATA) && (pos_reg == 4'd0) && !exh_reg;
    assign sts.nr      = (round_count_reg < 4'd10) ? 4'd10 :
                         (round_count_reg > 4'd14) ? 4'd14 : round_count_reg;

    // round key read: two words per round, registered in the cycle before use
    assign kr = cmd.ks_load ? 4'd0 :
                cmd.ks_key0 ? 4'd1 : cmd.ks_rnd + 4'd1;
    always_ff @(posedge clk)
    begin
        rk_hi <= rk_mem[5'({kr, 1'b0})];
        rk_lo <= rk_mem[5'({kr, 1'b1})];
    end

    assign lo_word = iv_low_reg ^ ctr_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sb[r + 4*c] = SBOX[st_reg[r + 4*((c + r) % 4)]];
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            mc[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        for (int i = 0; i < 16; i++)
        begin
            logic [7:0] kb;
            kb = (i < 8) ? rk_lo[8*i +: 8] : rk_hi[8*(i-8) +: 8];
            if (cmd.ks_load)
                st_next[i] = (i < 8) ? iv_high_reg[8*(7-i) +: 8]
                                     : lo_word[8*(15-i) +: 8];
            else if (cmd.ks_key0)
                st_next[i] = st_reg[i] ^ kb;
            else if (cmd.ks_round)
                st_next[i] = (cmd.ks_last ? sb[i] : mc[i]) ^ kb;
            else
                st_next[i] = st_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
            st_reg[i] <= st_next[i];
        if (cmd.ks_done)
            for (int i = 0; i < 16; i++)
                ks_reg[8*i +: 8] <= st_next[i];
    end

    assign idx = (ctr_reg - init_ctr_reg) & ctr_mask_reg;

    always_comb
    begin
        ctr_next = ctr_reg;
        pos_next = pos_reg;
        exh_next = exh_reg;
        res_byte = 8'd0;
        res_ok   = 1'b1;
        unique case (mode_reg)
            MODE_KEY: ;
            MODE_RESTART:
            begin
                ctr_next = init_ctr_reg;
                pos_next = 4'd0;
                exh_next = 1'b0;
            end
            MODE_NONE: res_ok = 1'b0;
            MODE_DATA:
            begin
                if (pos_reg == 4'd0 && exh_reg)
                begin
                    res_byte = byte_reg;
                    res_ok   = 1'b0;
                end
                else
                begin
                    res_byte = byte_reg ^ ks_reg[{pos_reg, 3'b000} +: 8];
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd15)
                    begin
                        exh_next = (idx == ctr_mask_reg);
                        ctr_next = (ctr_reg + 64'd1) & ctr_mask_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
            pos_reg <= '0;
            exh_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            ctr_reg <= ctr_next;
            pos_reg <= pos_next;
            exh_reg <= exh_next;
        end
    end
endmodule

// ===== rtl/aes_ctr_byte_stream.sv =====
// Sequence: every word passes IDLE, DEC and DONE; a data word that opens a 16-byte block
//   if not exhausted also runs KEY0 and one ROUND per round (AES runs a round per cycle).
// Throughput: one word at a time; no new word is taken until the result is loaded
//   into the output register, and DONE waits while that register is full and not drained.
// Reset (rst_n, async low): counter, position and exhausted flag cleared,
//   registers at defaults; round keys undefined until written.
module aes_ctr_byte_stream
#(
    parameter int ROUND_KEY_WORDS = acbs_pkg::ROUND_KEY_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: [7:0] data_byte, [12:8] key_index, [76:13] key_word, rest zero
    input  logic [79:0] s_tdata,
    // tuser: [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: [7:0] out_byte
    output logic [7:0]  m_tdata,
    // tuser: [0] ok
    output logic        m_tuser
);
    import acbs_pkg::*;

    acbs_cmd_t  cmd;
    acbs_sts_t  sts;
    logic       busy;
    logic       in_fire;
    logic       out_free;
    logic [7:0] res_byte;
    logic       res_ok;
    logic       m_tvalid_reg;
    logic [7:0] m_byte_reg;
    logic       m_ok_reg;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    // output register is empty or is being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    acbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    acbs_dp #(.ROUND_KEY_WORDS(ROUND_KEY_WORDS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_mode      (s_tuser),
        .in_data_byte (s_tdata[7:0]),
        .in_key_index (s_tdata[12:8]),
        .in_key_word  (s_tdata[76:13]),
        .cmd          (cmd),
        .sts          (sts),
        .res_byte     (res_byte),
        .res_ok       (res_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_byte_reg <= res_byte;
            m_ok_reg   <= res_ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_ok_reg;

    // Never accept while the controller is working on a word.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready)
        else $error("input accepted while busy");

    // A result is only produced when the output register can take it.
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output overwritten");

    // An accepted word leads to busy in the next cycle.
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy)
        else $error("controller missed a word");
endmodule

// ===== tb/tb_aes_ctr_byte_stream.sv =====
module tb_aes_ctr_byte_stream;
    import acbs_pkg::*;

    localparam int  KEY_WORDS   = 30;
    localparam int  DRAIN_WAIT  = 24;
    localparam int  CYCLE_LIMIT = 600000;

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  data_byte;
        logic [4:0]  key_index;
        logic [63:0] key_word;
    } word_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       ok;
    } cipher_out_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;      // [7:0] data_byte, [12:8] key_index, [76:13] key_word
    logic [1:0]  s_tuser = '0;      // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;           // [7:0] out_byte
    logic        m_tuser;           // [0] ok

    aes_ctr_byte_stream uut (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // shadow of the cipher state and its registers
    logic [63:0] iv_hi, iv_lo, ctr_init, ctr_mask, ctr_run;
    logic [3:0]  rounds_reg, blk_pos;
    logic        ctr_spent;
    logic [7:0]  ks_bytes [16];
    logic [63:0] key_store [KEY_WORDS];

    word_t       pending_words [$];
    cipher_out_t expected_bytes [$];
    int          src_idle_pct = 0, snk_stall_pct = 0;
    int          errors = 0, cycles = 0, n_out = 0, n_refused = 0;
    logic        took = 0;

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] round_key_byte(input int rnd, input int i);
        int idx;
        idx = 2 * rnd + (i < 8 ? 1 : 0);
        if (idx >= KEY_WORDS)
            return 8'h00;
        return key_store[idx][8*(i%8) +: 8];
    endfunction

    // encrypt {iv_hi, iv_lo ^ counter}, big-endian, into ks_bytes
    function automatic void build_keystream();
        logic [7:0]  s [16];
        logic [7:0]  t [16];
        logic [7:0]  a0, a1, a2, a3, all;
        logic [63:0] lo;
        int          nr;
        lo = iv_lo ^ ctr_run;
        nr = rounds_reg;
        if (nr < 10) nr = 10;
        if (nr > 14) nr = 14;
        for (int i = 0; i < 8; i++)
        begin
            s[i]     = iv_hi[8*(7-i) +: 8];
            s[8 + i] = lo[8*(7-i) +: 8];
        end
        for (int i = 0; i < 16; i++)
            s[i] ^= round_key_byte(0, i);
        for (int rnd = 1; rnd <= nr; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
            if (rnd != nr)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
                    t[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
                    t[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
                    t[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ round_key_byte(rnd, i);
        end
        ks_bytes = s;
    endfunction

    function automatic cipher_out_t cipher_step(input word_t w);
        cipher_out_t r;
        r.out_byte = 8'h00;
        r.ok = 1'b1;
        case (w.mode)
            MODE_KEY:
                if (w.key_index < KEY_WORDS)
                    key_store[w.key_index] = w.key_word;
            MODE_RESTART:
            begin
                ctr_run = ctr_init;
                blk_pos = 4'd0;
                ctr_spent = 1'b0;
            end
            MODE_NONE:
                r.ok = 1'b0;
            default:
                if (blk_pos == 4'd0 && ctr_spent)
                begin
                    r.out_byte = w.data_byte;
                    r.ok = 1'b0;
                end
                else
                begin
                    if (blk_pos == 4'd0)
                        build_keystream();
                    r.out_byte = w.data_byte ^ ks_bytes[blk_pos];
                    if (blk_pos == 4'd15)
                    begin
                        // block index reaching the mask marks the counter used up
                        ctr_spent = (((ctr_run - ctr_init) & ctr_mask) == ctr_mask);
                        ctr_run = (ctr_run + 64'd1) & ctr_mask;
                    end
                    blk_pos = blk_pos + 4'd1;
                end
        endcase
        return r;
    endfunction

    // driver: new word at the falling edge once the current one is taken
    always @(negedge clk)
    begin
        word_t w;
        if (rst_n)
        begin
            if (!s_tvalid || took)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    w = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, w.key_word, w.key_index, w.data_byte};
                    s_tuser  <= w.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge clk)
    begin
        word_t       w;
        cipher_out_t e;
        took <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            w.mode      = s_tuser;
            w.data_byte = s_tdata[7:0];
            w.key_index = s_tdata[12:8];
            w.key_word  = s_tdata[76:13];
            expected_bytes.push_back(cipher_step(w));
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            n_out++;
            if (!m_tuser)
                n_refused++;
            if (expected_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, actual byte %h ok %b", $time, m_tdata, m_tuser);
            end
            else
            begin
                e = expected_bytes.pop_front();
                if (m_tdata !== e.out_byte)
                begin
                    errors++;
                    $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, m_tdata);
                end
                if (m_tuser !== e.ok)
                begin
                    errors++;
                    $display("%0t: ok expected %b actual %b", $time, e.ok, m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_word(input logic [1:0] m, input logic [7:0] d,
                            input logic [4:0] ki, input logic [63:0] kw);
        word_t w;
        w.mode = m; w.data_byte = d; w.key_index = ki; w.key_word = kw;
        pending_words.push_back(w);
    endtask

    // sender holds off until every queued word is through and the core is quiet
    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IV_HIGH:     iv_hi = val;
            REG_IV_LOW:      iv_lo = val;
            REG_INIT_CTR:    ctr_init = val;
            REG_CTR_MASK:    ctr_mask = val;
            REG_ROUND_COUNT: rounds_reg = val[3:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [63:0] ivh, input logic [63:0] ivl,
                                 input logic [63:0] ci, input logic [63:0] cm,
                                 input logic [3:0] rc);
        write_reg(REG_IV_HIGH, ivh);
        write_reg(REG_IV_LOW, ivl);
        write_reg(REG_INIT_CTR, ci);
        write_reg(REG_CTR_MASK, cm);
        write_reg(REG_ROUND_COUNT, {60'd0, rc});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly byte runs, with restarts, key rewrites and the unused mode mixed in
    task automatic random_words(input int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 80)
                add_word(MODE_DATA, 8'($urandom), 5'($urandom), rand64());
            else if (k < 90)
                add_word(MODE_RESTART, 8'($urandom), 5'($urandom), rand64());
            else if (k < 97)
                add_word(MODE_KEY, 8'($urandom), 5'($urandom_range(31)), rand64());
            else
                add_word(MODE_NONE, 8'($urandom), 5'($urandom), rand64());
        end
    endtask

    initial
    begin
        logic [63:0] masks [5];
        logic [3:0]  rcs [5];
        logic [63:0] inits [5];
        iv_hi = '0; iv_lo = '0; ctr_init = '0; ctr_mask = CTR_MASK_RESET;
        rounds_reg = ROUND_COUNT_RESET;
        ctr_run = '0; blk_pos = 4'd0; ctr_spent = 1'b0;
        foreach (key_store[i]) key_store[i] = '0;
        foreach (ks_bytes[i]) ks_bytes[i] = 8'h00;

        repeat (3) @(negedge clk);
        rst_n = 1;

        // every round-key word gets a value before any keystream is built
        for (int i = 0; i < KEY_WORDS; i++)
            add_word(MODE_KEY, 8'h00, i[4:0], rand64());
        // key indexes past the store are dropped
        add_word(MODE_KEY, 8'hff, 5'd30, 64'hffff_ffff_ffff_ffff);
        add_word(MODE_KEY, 8'h00, 5'd31, 64'h0);
        drain();

        // directed: mask 0 uses up the counter after one block
        load_settings(64'hffff_ffff_ffff_ffff, 64'h0, 64'hffff_ffff_ffff_ffff, 64'h0, 4'd14);
        add_word(MODE_DATA, 8'h00, 5'h1f, 64'h0);
        add_word(MODE_DATA, 8'hff, 5'h00, 64'hffff_ffff_ffff_ffff);
        add_word(MODE_NONE, 8'ha5, 5'h00, 64'h0);
        for (int i = 0; i < 14; i++)
            add_word(MODE_DATA, 8'($urandom), 5'h00, 64'h0);
        add_word(MODE_DATA, 8'h5a, 5'h00, 64'h0);      // refused, counter spent
        add_word(MODE_DATA, 8'hff, 5'h00, 64'h0);      // still refused
        add_word(MODE_RESTART, 8'h00, 5'h00, 64'h0);
        add_word(MODE_DATA, 8'h3c, 5'h00, 64'h0);      // accepted again
        add_word(MODE_RESTART, 8'h00, 5'h00, 64'h0);   // mid-block restart
        add_word(MODE_DATA, 8'h00, 5'h00, 64'h0);
        drain();

        masks = '{64'h1, 64'h3, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h7};
        rcs   = '{4'd10, 4'd12, 4'd15, 4'd0, 4'd11};
        inits = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h5, 64'h0};
        for (int p = 0; p < 5; p++)
        begin
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 75; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 75; end
                default: begin src_idle_pct = 36; snk_stall_pct = 36; end
            endcase
            load_settings(rand64(), (p == 2) ? 64'hffff_ffff_ffff_ffff : rand64(),
                          inits[p] & masks[p], masks[p], rcs[p]);
            add_word(MODE_RESTART, 8'h00, 5'h00, 64'h0);
            random_words(100);
            drain();
        end

        $display("Ran %0d output words (%0d refused) over six register settings,",
                 n_out, n_refused);
        $display("round counts from 0 to 15 and counter masks from 0 to all ones.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
